// ----- hw/rtl/blob_track_table_defines.svh -----
// Assertion shorthands for the blob track table checker.
`ifndef BLOB_TRACK_TABLE_DEFINES_SVH
`define BLOB_TRACK_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk, held off during reset.
`define BTT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, held off during reset.
`define BTT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/btt_pkg.sv -----
package btt_pkg;

    localparam int MAX_TRACKS = 64;
    localparam int COORD_BITS = 12;

    localparam int CTR_W   = COORD_BITS + 1;
    localparam int IDX_W   = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
    localparam int CNT_W   = $clog2(MAX_TRACKS + 1);
    localparam int SCAN_W  = $clog2(MAX_TRACKS + 2);
    localparam int SQ_W    = 2 * CTR_W;
    localparam int SUM_W   = SQ_W + 1;
    localparam int R_SQ_W  = 2 * COORD_BITS;

    localparam int OUT_IDX_W = 6;
    localparam int OUT_CNT_W = 7;

    localparam int SEARCH_LIMIT = 500;
    localparam logic [SUM_W-1:0] SEARCH_LIMIT_SQ = SUM_W'(SEARCH_LIMIT * SEARCH_LIMIT);

    localparam int CFG_IDX_W = 3;

    localparam logic [COORD_BITS-1:0] RST_CENTER_X = COORD_BITS'(622);
    localparam logic [COORD_BITS-1:0] RST_CENTER_Y = COORD_BITS'(522);
    localparam logic [COORD_BITS-1:0] RST_RADIUS   = COORD_BITS'(495);
    localparam logic [COORD_BITS-1:0] RST_MARGIN   = COORD_BITS'(35);
    localparam logic [COORD_BITS-1:0] RST_MIN_SIZE = COORD_BITS'(4);
    localparam logic [COORD_BITS-1:0] RST_MERGE    = COORD_BITS'(20);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_X = 3'd0,
        REG_CENTER_Y = 3'd1,
        REG_RADIUS   = 3'd2,
        REG_MARGIN   = 3'd3,
        REG_MIN_SIZE = 3'd4,
        REG_MERGE    = 3'd5
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ACT_SMALL   = 3'd0,
        ACT_OUTSIDE = 3'd1,
        ACT_APPEND  = 3'd2,
        ACT_UPDATE  = 3'd3,
        ACT_FULL    = 3'd4,
        ACT_CLEAR   = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_REGION,
        S_SCAN,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic                  req_type;
        logic [COORD_BITS-1:0] box_x;
        logic [COORD_BITS-1:0] box_y;
        logic [COORD_BITS-1:0] box_width;
        logic [COORD_BITS-1:0] box_height;
        logic                  dim_frame;
    } req_t;

    typedef struct packed {
        action_t               action;
        logic [OUT_IDX_W-1:0]  entry_index;
        logic [CTR_W-1:0]      center_x;
        logic [CTR_W-1:0]      center_y;
        logic [OUT_CNT_W-1:0]  tracked_count;
    } res_t;

    typedef struct packed {
        logic [CTR_W-1:0] x;
        logic [CTR_W-1:0] y;
    } point_t;

    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctl_t;

    typedef struct packed {
        logic             vld;
        logic [IDX_W-1:0] idx;
    } dist_tag_t;

endpackage

// ----- hw/rtl/blob_track_table.sv -----
// Tracked blob table. A word is taken when start is high and busy is low; each word
// yields exactly one result word, shown on result for the single cycle in which done
// is high, and the receiver must take it then. A clear word or a too-small candidate
// answers in the cycle after acceptance. A candidate outside the region answers once
// its region check has left the distance unit; every other candidate answers after the
// stored centers rotate once around the chain of cells past the single two-stage
// distance unit, one entry per cycle, plus the region check ahead of it and the
// write-back after it. Busy is high through region check, scan and write-back,
// and one word is in work at a time. The user must write the configuration registers
// through cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
module blob_track_table
    import btt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  req_t                 req,
    output logic                 busy,
    output logic                 done,
    output res_t                 result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COORD_BITS-1:0] cfg_data
);

    state_t state_reg, state_next;
    logic [SCAN_W-1:0] sc_reg, sc_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              found_reg, found_next;
    logic              done_reg, done_next;

    logic [COORD_BITS-1:0] cfg_cx_reg, cfg_cy_reg, cfg_radius_reg;
    logic [COORD_BITS-1:0] cfg_margin_reg, cfg_min_reg, cfg_merge_reg;

    point_t                cand_reg, cand_next;
    logic [COORD_BITS-1:0] ar_reg, ar_next;
    logic [R_SQ_W-1:0]     sr_reg, sr_next;
    logic [R_SQ_W-1:0]     sm_reg, sm_next;
    logic [SUM_W-1:0]      best_reg, best_next;
    logic [IDX_W-1:0]      best_idx_reg, best_idx_next;
    res_t                  res_reg, res_next;

    point_t    cell_pt  [MAX_TRACKS];
    cell_ctl_t cell_ctl [MAX_TRACKS];

    dist_tag_t        feed_tag, dist_tag;
    point_t           feed_b, region_pt;
    logic [SUM_W-1:0] dist_sum;

    logic             accept;
    logic [COORD_BITS-1:0] side;
    logic [CTR_W-1:0] thr;
    point_t           cx_pt;
    logic             too_small;
    logic             region_in;
    logic             scan_last;
    logic             upd;
    logic             full;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;

    assign accept    = start && !busy;
    assign side      = (req.box_width > req.box_height) ? req.box_width : req.box_height;
    assign thr       = req.dim_frame ? {cfg_min_reg, 1'b0} : {1'b0, cfg_min_reg};
    assign cx_pt.x   = CTR_W'(req.box_x) + CTR_W'(req.box_width >> 1);
    assign cx_pt.y   = CTR_W'(req.box_y) + CTR_W'(req.box_height >> 1);
    assign too_small = CTR_W'(side) <= thr;
    assign region_pt.x = CTR_W'(cfg_cx_reg);
    assign region_pt.y = CTR_W'(cfg_cy_reg);
    assign region_in = dist_sum < SUM_W'(sr_reg);
    assign scan_last = sc_reg == SCAN_W'(MAX_TRACKS + 1);
    assign upd       = found_reg && (best_reg <= SUM_W'(sm_reg));
    assign full      = count_reg >= CNT_W'(MAX_TRACKS);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_cx_reg     <= RST_CENTER_X;
            cfg_cy_reg     <= RST_CENTER_Y;
            cfg_radius_reg <= RST_RADIUS;
            cfg_margin_reg <= RST_MARGIN;
            cfg_min_reg    <= RST_MIN_SIZE;
            cfg_merge_reg  <= RST_MERGE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CENTER_X: cfg_cx_reg     <= cfg_data;
                REG_CENTER_Y: cfg_cy_reg     <= cfg_data;
                REG_RADIUS:   cfg_radius_reg <= cfg_data;
                REG_MARGIN:   cfg_margin_reg <= cfg_data;
                REG_MIN_SIZE: cfg_min_reg    <= cfg_data;
                REG_MERGE:    cfg_merge_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && !req.req_type && !too_small)
                begin
                    state_next = S_REGION;
                end
            end
            S_REGION:
            begin
                if (sc_reg == SCAN_W'(2))
                begin
                    state_next = region_in ? S_SCAN : S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control outputs: chain rotation, distance feed, cell writes
    always_comb
    begin
        busy         = state_reg != S_IDLE;
        feed_tag.vld = (state_reg == S_SCAN) && (sc_reg < SCAN_W'(count_reg));
        feed_tag.idx = sc_reg[IDX_W-1:0];
        feed_b       = (state_reg == S_REGION) ? region_pt : cell_pt[0];
        wr_en        = (state_reg == S_FINISH) && (upd || !full);
        wr_idx       = upd ? best_idx_reg : count_reg[IDX_W-1:0];
        for (int i = 0; i < MAX_TRACKS; i++)
        begin
            cell_ctl[i].shift = (state_reg == S_SCAN) && (sc_reg < SCAN_W'(MAX_TRACKS));
            cell_ctl[i].load  = wr_en && (wr_idx == IDX_W'(i));
        end
    end

    // datapath
    always_comb
    begin
        sc_next       = sc_reg;
        count_next    = count_reg;
        found_next    = found_reg;
        done_next     = 1'b0;
        cand_next     = cand_reg;
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        res_next      = res_reg;
        ar_next       = (cfg_radius_reg >= cfg_margin_reg) ?
                        (cfg_radius_reg - cfg_margin_reg) : (cfg_margin_reg - cfg_radius_reg);
        sr_next       = R_SQ_W'(ar_reg) * R_SQ_W'(ar_reg);
        sm_next       = R_SQ_W'(cfg_merge_reg) * R_SQ_W'(cfg_merge_reg);

        // keep the nearest entry strictly closer than the best so far
        if (dist_tag.vld && (dist_sum < best_reg))
        begin
            best_next     = dist_sum;
            best_idx_next = dist_tag.idx;
            found_next    = 1'b1;
        end

        case (state_reg)
            S_IDLE:
            begin
                sc_next = '0;
                if (accept)
                begin
                    if (req.req_type)
                    begin
                        count_next = '0;
                        res_next   = '{ACT_CLEAR, '0, '0, '0, '0};
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        cand_next = cx_pt;
                        if (too_small)
                        begin
                            res_next  = '{ACT_SMALL, '0, cx_pt.x, cx_pt.y,
                                          OUT_CNT_W'(count_reg)};
                            done_next = 1'b1;
                        end
                    end
                end
            end
            S_REGION:
            begin
                sc_next = sc_reg + SCAN_W'(1);
                if (sc_reg == SCAN_W'(2))
                begin
                    sc_next    = '0;
                    best_next  = SEARCH_LIMIT_SQ;
                    found_next = 1'b0;
                    if (!region_in)
                    begin
                        res_next  = '{ACT_OUTSIDE, '0, cand_reg.x, cand_reg.y,
                                      OUT_CNT_W'(count_reg)};
                        done_next = 1'b1;
                    end
                end
            end
            S_SCAN:
            begin
                sc_next = sc_reg + SCAN_W'(1);
            end
            S_FINISH:
            begin
                sc_next   = '0;
                done_next = 1'b1;
                if (upd)
                begin
                    res_next = '{ACT_UPDATE, OUT_IDX_W'(best_idx_reg), cand_reg.x,
                                 cand_reg.y, OUT_CNT_W'(count_reg)};
                end
                else if (full)
                begin
                    res_next = '{ACT_FULL, '0, cand_reg.x, cand_reg.y,
                                 OUT_CNT_W'(count_reg)};
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                    res_next   = '{ACT_APPEND, OUT_IDX_W'(count_reg[IDX_W-1:0]), cand_reg.x,
                                   cand_reg.y, OUT_CNT_W'(count_reg + CNT_W'(1))};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sc_reg    <= '0;
            count_reg <= '0;
            found_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sc_reg    <= sc_next;
            count_reg <= count_next;
            found_reg <= found_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg     <= cand_next;
        ar_reg       <= ar_next;
        sr_reg       <= sr_next;
        sm_reg       <= sm_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        res_reg      <= res_next;
    end

    // ring of entries; each cell takes its right neighbor when rotating
    for (genvar i = 0; i < MAX_TRACKS; i++)
    begin : g_cell
        localparam int NB = (i + 1) % MAX_TRACKS;
        btt_cell u_cell (
            .clk   (clk),
            .ctl   (cell_ctl[i]),
            .nbr   (cell_pt[NB]),
            .wr_pt (cand_reg),
            .pt    (cell_pt[i])
        );
    end

    btt_dist u_dist (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_tag  (feed_tag),
        .a       (cand_reg),
        .b       (feed_b),
        .out_tag (dist_tag),
        .sum     (dist_sum)
    );

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ----- hw/rtl/btt_cell.sv -----
module btt_cell
    import btt_pkg::*;
(
    input  logic      clk,
    input  cell_ctl_t ctl,
    input  point_t    nbr,
    input  point_t    wr_pt,
    output point_t    pt
);

    point_t pt_reg;

    // load and shift never coincide; load takes priority anyway
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            pt_reg <= wr_pt;
        end
        else if (ctl.shift)
        begin
            pt_reg <= nbr;
        end
    end

    assign pt = pt_reg;

endmodule

// ----- hw/rtl/btt_dist.sv -----
module btt_dist
    import btt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  dist_tag_t        in_tag,
    input  point_t           a,
    input  point_t           b,
    output dist_tag_t        out_tag,
    output logic [SUM_W-1:0] sum
);

    logic [CTR_W-1:0] adx_reg, adx_next;
    logic [CTR_W-1:0] ady_reg, ady_next;
    logic [SQ_W-1:0]  sx_reg, sx_next;
    logic [SQ_W-1:0]  sy_reg, sy_next;
    dist_tag_t        tag1_reg, tag2_reg;

    always_comb
    begin
        adx_next = (a.x >= b.x) ? (a.x - b.x) : (b.x - a.x);
        ady_next = (a.y >= b.y) ? (a.y - b.y) : (b.y - a.y);
        sx_next  = SQ_W'(adx_reg) * SQ_W'(adx_reg);
        sy_next  = SQ_W'(ady_reg) * SQ_W'(ady_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
        end
        else
        begin
            tag1_reg <= in_tag;
            tag2_reg <= tag1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        adx_reg <= adx_next;
        ady_reg <= ady_next;
        sx_reg  <= sx_next;
        sy_reg  <= sy_next;
    end

    assign out_tag = tag2_reg;
    assign sum     = SUM_W'(sx_reg) + SUM_W'(sy_reg);

endmodule

// ----- hw/rtl/btt_checker.sv -----
`include "blob_track_table_defines.svh"

module btt_checker
    import btt_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input res_t result
);

    `BTT_ASSERT_NEXT(a_accept_resp, start && !busy, busy || done, "accepted word got no response")
    `BTT_ASSERT_NOW(a_done_cause, done, $past(start && !busy) || $past(busy), "result without a word")
    `BTT_ASSERT_NOW(a_busy_end, $fell(busy), done, "busy dropped without a result")
    `BTT_ASSERT_NOW(a_clear_zero, done && (result.action == ACT_CLEAR), (result.tracked_count == '0) && (result.entry_index == '0), "clear left entries")
    `BTT_ASSERT_NOW(a_append_cnt, done && (result.action == ACT_APPEND), result.tracked_count != '0, "append with empty table")

endmodule

bind blob_track_table btt_checker u_chk (.*);
